@@ hw/rtl/ffbl_pkg.sv @@
// Shared types and constants of the fixed block free list allocator.
// Used by the core, the output buffer, the top level and the checker.
package ffbl_pkg;

    localparam int CNT_W     = 11;
    localparam int IDX_W     = 10;
    localparam int BYTES_W   = 17;
    localparam int OFF_W     = 27;
    localparam int CFG_IDX_W = 2;

    localparam int POOL_LIMIT = 1024;

    localparam logic [CNT_W-1:0]   RST_BLOCKS   = 11'd1024;
    localparam logic [BYTES_W-1:0] RST_BYTES    = 17'd64;
    localparam logic [BYTES_W-1:0] BYTES_MAX    = 17'd65536;
    localparam logic [BYTES_W-1:0] BYTES_MIN    = 17'd8;
    localparam logic [BYTES_W-1:0] ALIGN_MASK   = 17'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES  = 2'd1;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REFILL = 2'd2,
        CMD_NOP    = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NONE_USED = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    granted_index;
        logic [OFF_W-1:0]    granted_offset;
        logic [CNT_W-1:0]    used_count;
        logic [CNT_W-1:0]    free_count;
    } t_result;

endpackage

@@ hw/rtl/ffbl_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ffbl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ffbl_core.sv @@
// Free list state, stack top prefetch and per-request result computation.
// Depends on ffbl_pkg and ffbl_ram.
module ffbl_core
    import ffbl_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_command             i_command,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [CNT_W-1:0]     i_cfg_blocks,
    input  logic [BYTES_W-1:0]   i_cfg_bytes,
    output t_result              o_result
);

    localparam int CAP = (MAX_BLOCKS < POOL_LIMIT) ? MAX_BLOCKS : POOL_LIMIT;
    localparam int AW  = $clog2(CAP);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] req);
        logic [CNT_W-1:0] n;
        n = req;
        if (n == '0) begin
            n = CNT_W'(1);
        end
        if (n > CAP_CNT) begin
            n = CAP_CNT;
        end
        return n;
    endfunction

    function automatic logic [BYTES_W-1:0] align_stride(input logic [BYTES_W-1:0] req);
        logic [BYTES_W-1:0] n;
        n = req;
        if (n > BYTES_MAX) begin
            n = BYTES_MAX;
        end
        if (n < BYTES_MIN) begin
            n = BYTES_MIN;
        end
        return (n + ALIGN_MASK) & ~ALIGN_MASK;
    endfunction

    logic [CNT_W-1:0]   r_depth, n_depth;
    logic [CNT_W-1:0]   r_wm, n_wm;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_active, n_active;
    logic [BYTES_W-1:0] r_stride, n_stride;
    logic [AW-1:0]      r_top_pos;
    logic               r_top_ident;
    logic               r_fwd_valid;
    logic [IDX_W-1:0]   r_fwd_data;

    logic [CNT_W-1:0]   rd_pos;
    logic [IDX_W-1:0]   ram_rdata;
    logic [IDX_W-1:0]   top_val;
    logic               we;
    t_status            status;
    logic [IDX_W-1:0]   gidx;

    ffbl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAP)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (i_block_index),
        .i_raddr (rd_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign top_val = r_top_ident ? IDX_W'(r_top_pos)
                   : (r_fwd_valid ? r_fwd_data : ram_rdata);

    always_comb begin
        n_depth  = r_depth;
        n_wm     = r_wm;
        n_used   = r_used;
        n_active = r_active;
        n_stride = r_stride;
        status   = ST_OK;
        gidx     = '0;
        we       = 1'b0;
        if (i_accept) begin
            unique case (i_command)
                CMD_ALLOC: begin
                    if (r_depth == '0) begin
                        status = ST_EXHAUSTED;
                    end else begin
                        n_depth = r_depth - CNT_W'(1);
                        n_used  = r_used + CNT_W'(1);
                        gidx    = top_val;
                    end
                end
                CMD_FREE: begin
                    if ({1'b0, i_block_index} >= r_active) begin
                        status = ST_RANGE;
                    end else if (r_used == '0) begin
                        status = ST_NONE_USED;
                    end else begin
                        we      = 1'b1;
                        n_depth = r_depth + CNT_W'(1);
                        n_used  = r_used - CNT_W'(1);
                        if (r_depth < r_wm) begin
                            n_wm = r_depth;
                        end
                    end
                end
                CMD_REFILL: begin
                    n_active = sat_count(i_cfg_blocks);
                    n_stride = align_stride(i_cfg_bytes);
                    n_depth  = n_active;
                    n_wm     = n_active;
                    n_used   = '0;
                end
                CMD_NOP: begin
                end
                default: begin
                end
            endcase
        end
        rd_pos = n_depth - CNT_W'(1);
    end

    always_comb begin
        o_result.status         = status;
        o_result.granted_index  = gidx;
        o_result.granted_offset = OFF_W'(gidx) * OFF_W'(r_stride);
        o_result.used_count     = n_used;
        o_result.free_count     = n_depth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= sat_count(RST_BLOCKS);
            r_wm        <= sat_count(RST_BLOCKS);
            r_used      <= '0;
            r_active    <= sat_count(RST_BLOCKS);
            r_stride    <= align_stride(RST_BYTES);
            r_top_pos   <= AW'(CAP - 1);
            r_top_ident <= 1'b1;
            r_fwd_valid <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_wm        <= n_wm;
            r_used      <= n_used;
            r_active    <= n_active;
            r_stride    <= n_stride;
            r_top_pos   <= rd_pos[AW-1:0];
            r_top_ident <= (rd_pos < n_wm);
            r_fwd_valid <= we;
        end
        r_fwd_data <= i_block_index;
    end

endmodule

@@ hw/rtl/ffbl_skid.sv @@
// Two-entry output buffer: result register plus skid register.
// Depends on ffbl_pkg.
module ffbl_skid
    import ffbl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

@@ hw/rtl/fixed_block_free_list_allocator.sv @@
// Top level of the fixed block free list allocator: configuration registers,
// core and output buffer. Depends on ffbl_pkg, ffbl_core and ffbl_skid.
// Results are registered in the output buffer; throughput is one request
// per cycle while it has space; the stack top is prefetched from the RAM.
// Reset is synchronous and active low; it leaves all blocks free with the
// default configuration, and needs no clearing pass over the stack memory.
module fixed_block_free_list_allocator
    import ffbl_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_command,
    input  logic [IDX_W-1:0]     i_block_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [IDX_W-1:0]     o_granted_index,
    output logic [OFF_W-1:0]     o_granted_offset,
    output logic [CNT_W-1:0]     o_used_count,
    output logic [CNT_W-1:0]     o_free_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTES_W-1:0]   i_cfg_data
);

    logic [CNT_W-1:0]   r_cfg_blocks;
    logic [BYTES_W-1:0] r_cfg_bytes;
    logic               accept;
    logic               space;
    t_result            core_result;
    t_result            out_result;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = space;
    assign accept      = i_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_blocks <= RST_BLOCKS;
            r_cfg_bytes  <= RST_BYTES;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_BLOCKS) begin
                r_cfg_blocks <= i_cfg_data[CNT_W-1:0];
            end else if (i_cfg_index == CFG_BYTES) begin
                r_cfg_bytes <= i_cfg_data;
            end
        end
    end

    ffbl_core #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (t_command'(i_command)),
        .i_block_index (i_block_index),
        .i_cfg_blocks  (r_cfg_blocks),
        .i_cfg_bytes   (r_cfg_bytes),
        .o_result      (core_result)
    );

    ffbl_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_result),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_result)
    );

    assign o_status         = out_result.status;
    assign o_granted_index  = out_result.granted_index;
    assign o_granted_offset = out_result.granted_offset;
    assign o_used_count     = out_result.used_count;
    assign o_free_count     = out_result.free_count;

endmodule

@@ hw/rtl/ffbl_checker.sv @@
// Port-level checker for the fixed block free list allocator, bound to the top.
// Depends on ffbl_pkg.
module ffbl_checker
    import ffbl_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [1:0]           o_status,
    input logic [IDX_W-1:0]     o_granted_index,
    input logic [OFF_W-1:0]     o_granted_offset,
    input logic [CNT_W-1:0]     o_used_count,
    input logic [CNT_W-1:0]     o_free_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_granted_index)
            && $stable(o_used_count) && $stable(o_free_count))
        else $error("Result changed while stalled.");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_used_count} + {1'b0, o_free_count}) <= 12'd1024)
        else $error("Used and free counts exceed the pool.");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_granted_index == '0 && o_granted_offset == '0)
        else $error("Failed request reports a granted block.");

    a_exhausted_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EXHAUSTED |-> o_free_count == '0)
        else $error("Exhaustion reported with free blocks left.");

    a_zero_index_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_granted_index == '0 |-> o_granted_offset == '0)
        else $error("Block zero reported with a nonzero offset.");

endmodule

bind fixed_block_free_list_allocator ffbl_checker u_ffbl_checker (.*);

@@ tb/fixed_block_free_list_allocator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the fixed block free list allocator.
// Needs ffbl_pkg and the allocator RTL; drives requests and configuration writes
// and checks every result against a built-in model of the LIFO free list.
module fixed_block_free_list_allocator_tb;
    import ffbl_pkg::*;

    localparam int SLOTS = 1024;
    localparam int LONG_HOLD = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        t_command         cmd;
        logic [IDX_W-1:0] idx;
    } t_request;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_command = CMD_NOP;
    logic [IDX_W-1:0]     i_block_index = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_status;
    logic [IDX_W-1:0]     o_granted_index;
    logic [OFF_W-1:0]     o_granted_offset;
    logic [CNT_W-1:0]     o_used_count;
    logic [CNT_W-1:0]     o_free_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTES_W-1:0]   i_cfg_data = '0;

    fixed_block_free_list_allocator #(
        .MAX_BLOCKS(SLOTS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_command(i_command),
        .i_block_index(i_block_index),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_granted_index(o_granted_index),
        .o_granted_offset(o_granted_offset),
        .o_used_count(o_used_count),
        .o_free_count(o_free_count),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_request         req_queue[$];
    t_result          expected_results[$];
    logic [IDX_W-1:0] held_blocks[$];
    int               mismatches = 0;

    logic             idle_en = 1'b0;
    logic             long_hold = 1'b0;
    logic             hold_done = 1'b0;
    int               hold_ticks = 0;
    int               send_gap = 0;
    int               recv_gap = 0;
    logic             drv_busy;

    logic [IDX_W-1:0]   slot_mem [SLOTS];
    logic [CNT_W-1:0]   pool_depth;
    logic [CNT_W-1:0]   pool_mark;
    logic [CNT_W-1:0]   pool_used;
    logic [CNT_W-1:0]   pool_count;
    logic [BYTES_W-1:0] pool_stride;
    logic [CNT_W-1:0]   cfg_blocks;
    logic [BYTES_W-1:0] cfg_bytes;

    function automatic logic [BYTES_W-1:0] align_bytes(input logic [BYTES_W-1:0] req);
        logic [BYTES_W:0] r;
        r = {1'b0, req};
        if (r > {1'b0, BYTES_MAX}) r = {1'b0, BYTES_MAX};
        if (r < {1'b0, BYTES_MIN}) r = {1'b0, BYTES_MIN};
        r = (r + {1'b0, ALIGN_MASK}) & ~{1'b0, ALIGN_MASK};
        return r[BYTES_W-1:0];
    endfunction

    task automatic refill_pool();
        logic [CNT_W-1:0] n;
        n = cfg_blocks;
        if (n == 0) n = CNT_W'(1);
        if (n > POOL_LIMIT) n = CNT_W'(POOL_LIMIT);
        pool_count  = n;
        pool_stride = align_bytes(cfg_bytes);
        pool_depth  = n;
        pool_mark   = n;
        pool_used   = '0;
        held_blocks.delete();
    endtask

    task automatic model_request(input logic [1:0] cmd, input logic [IDX_W-1:0] idx);
        t_result          r;
        logic [IDX_W-1:0] g;
        r = '0;
        r.status = ST_OK;
        case (t_command'(cmd))
            CMD_ALLOC: begin
                if (pool_depth == 0) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    pool_depth = pool_depth - 1'b1;
                    g = (pool_depth < pool_mark) ? pool_depth[IDX_W-1:0]
                                                 : slot_mem[pool_depth[IDX_W-1:0]];
                    pool_used = pool_used + 1'b1;
                    r.granted_index  = g;
                    r.granted_offset = OFF_W'(g) * OFF_W'(pool_stride);
                    held_blocks.push_back(g);
                end
            end
            CMD_FREE: begin
                if ({1'b0, idx} >= pool_count) begin
                    r.status = ST_RANGE;
                end else if (pool_used == 0) begin
                    r.status = ST_NONE_USED;
                end else if (pool_depth < SLOTS) begin
                    slot_mem[pool_depth[IDX_W-1:0]] = idx;
                    if (pool_depth < pool_mark) pool_mark = pool_depth;
                    pool_depth = pool_depth + 1'b1;
                    pool_used  = pool_used - 1'b1;
                end
            end
            CMD_REFILL: refill_pool();
            default: ;
        endcase
        r.used_count = pool_used;
        r.free_count = pool_depth;
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [OFF_W-1:0] want,
                               input logic [OFF_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            drv_busy = i_valid;
            if (i_valid && o_ready) begin
                model_request(i_command, i_block_index);
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (idle_en && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 18);
                    i_valid  <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    i_valid       <= 1'b1;
                    i_command     <= req_queue[0].cmd;
                    i_block_index <= req_queue[0].idx;
                    void'(req_queue.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!long_hold) begin
            hold_ticks <= 0;
            hold_done  <= 1'b0;
        end else if (hold_ticks == LONG_HOLD) begin
            hold_done <= 1'b1;
        end else begin
            hold_ticks <= hold_ticks + 1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none, actual status %0d index %0d",
                             $time, o_status, o_granted_index);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", OFF_W'(want.status), OFF_W'(o_status));
                    check_field("granted_index", OFF_W'(want.granted_index),
                                OFF_W'(o_granted_index));
                    check_field("granted_offset", want.granted_offset, o_granted_offset);
                    check_field("used_count", OFF_W'(want.used_count), OFF_W'(o_used_count));
                    check_field("free_count", OFF_W'(want.free_count), OFF_W'(o_free_count));
                end
            end
            if (long_hold && !hold_done) begin
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready  <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 18);
                i_ready  <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic offer(input t_command cmd, input logic [IDX_W-1:0] idx);
        t_request q;
        q.cmd = cmd;
        q.idx = idx;
        req_queue.push_back(q);
        while (req_queue.size() > 2) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        forever begin
            @(negedge i_clk);
            if (req_queue.size() == 0 && !i_valid && expected_results.size() == 0) break;
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTES_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == CFG_BLOCKS) cfg_blocks = data[CNT_W-1:0];
        else if (idx == CFG_BYTES) cfg_bytes = data;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic offer_random();
        int               r;
        int               pick;
        logic [IDX_W-1:0] idx;
        r   = $urandom_range(0, 99);
        idx = IDX_W'($urandom_range(0, 1023));
        if (r < 45) begin
            offer(CMD_ALLOC, idx);
        end else if (r < 89) begin
            if (held_blocks.size() > 0 && $urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, held_blocks.size() - 1);
                idx  = held_blocks[pick];
                held_blocks.delete(pick);
            end else if ($urandom_range(0, 1) == 0) begin
                idx = IDX_W'($urandom_range(0, pool_count));
            end
            offer(CMD_FREE, idx);
        end else if (r < 95) begin
            offer(CMD_REFILL, idx);
        end else begin
            offer(CMD_NOP, idx);
        end
    endtask

    task automatic pick_config();
        int               r;
        logic [BYTES_W-1:0] data;
        r = $urandom_range(0, 99);
        if (r < 60) data = BYTES_W'($urandom_range(1, 24));
        else if (r < 75) data = BYTES_W'($urandom_range(25, 1024));
        else if (r < 90) data = BYTES_W'($urandom_range(0, 131071));
        else begin
            case ($urandom_range(0, 3))
                0: data = 17'd0;
                1: data = 17'd1;
                2: data = 17'd1024;
                default: data = 17'd2047;
            endcase
        end
        write_reg(CFG_BLOCKS, data);
        r = $urandom_range(0, 99);
        if (r < 50) data = BYTES_W'($urandom_range(1, 200));
        else if (r < 80) data = BYTES_W'($urandom_range(0, 131071));
        else begin
            case ($urandom_range(0, 5))
                0: data = 17'd0;
                1: data = 17'd1;
                2: data = 17'd8;
                3: data = 17'd65536;
                4: data = 17'd65537;
                default: data = 17'd131071;
            endcase
        end
        write_reg(CFG_BYTES, data);
    endtask

    initial begin
        for (int k = 0; k < SLOTS; k++) slot_mem[k] = '0;
        cfg_blocks = RST_BLOCKS;
        cfg_bytes  = RST_BYTES;
        refill_pool();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default pool: unused command, frees with nothing allocated, repeated free.
        offer(CMD_NOP, 10'd0);
        offer(CMD_FREE, 10'd5);
        offer(CMD_FREE, 10'd1023);
        offer(CMD_ALLOC, 10'd1023);
        offer(CMD_ALLOC, 10'd0);
        offer(CMD_FREE, 10'd1023);
        offer(CMD_FREE, 10'd1023);
        offer(CMD_FREE, 10'd0);
        wait_drained();

        // Single block of minimum size: exhaustion and range checks.
        write_reg(CFG_BLOCKS, 17'd0);
        write_reg(CFG_BYTES, 17'd0);
        write_reg(CFG_SPARE, 17'h1FFFF);
        offer(CMD_REFILL, 10'h3FF);
        offer(CMD_ALLOC, 10'd0);
        offer(CMD_ALLOC, 10'd0);
        offer(CMD_FREE, 10'd1);
        offer(CMD_FREE, 10'd0);
        offer(CMD_FREE, 10'd0);
        offer(CMD_FREE, 10'd1023);
        wait_drained();

        // Oversized count and block size saturate; largest offset.
        write_reg(CFG_BLOCKS, 17'd2047);
        write_reg(CFG_BYTES, 17'd131071);
        offer(CMD_REFILL, 10'd0);
        offer(CMD_ALLOC, 10'd0);
        offer(CMD_FREE, 10'd1023);
        wait_drained();

        // New settings wait for the next refill.
        write_reg(CFG_BLOCKS, 17'd3);
        write_reg(CFG_BYTES, 17'd9);
        offer(CMD_ALLOC, 10'd0);
        offer(CMD_REFILL, 10'd0);
        repeat (4) offer(CMD_ALLOC, 10'h2AA);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            idle_en = (phase != 3 && phase != 5);
            pick_config();
            if (phase == 1) write_reg(CFG_SPARE, BYTES_W'($urandom_range(0, 131071)));
            offer(CMD_REFILL, IDX_W'($urandom_range(0, 1023)));
            if (phase == 2) begin
                long_hold = 1'b1;
                for (int n = 0; n < 40; n++) offer_random();
                while (!hold_done) @(negedge i_clk);
                long_hold = 1'b0;
                for (int n = 0; n < 35; n++) offer_random();
            end else begin
                for (int n = 0; n < 75; n++) offer_random();
            end
            wait_drained();
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ffbl_pkg.sv
hw/rtl/ffbl_ram.sv
hw/rtl/ffbl_core.sv
hw/rtl/ffbl_skid.sv
hw/rtl/fixed_block_free_list_allocator.sv
hw/rtl/ffbl_checker.sv
tb/fixed_block_free_list_allocator_tb.sv
